### hw/rtl/deq_pkg.sv
// shared types and constants for the double-ended queue
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W      = 3;
    localparam int DIN_W     = 32;
    localparam int DOUT_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_HEAD = 3'd0,
        OP_PUSH_TAIL = 3'd1,
        OP_POP_HEAD  = 3'd2,
        OP_POP_TAIL  = 3'd3,
        OP_PEEK_HEAD = 3'd4,
        OP_PEEK_TAIL = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic take;       // word accepted this cycle
        logic rd_issue;   // ring read started for a pop or peek
        logic load_now;   // result known at once
        logic load_read;  // result comes from the ring read data
    } deq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
    } deq_flags_t;

    function automatic logic is_read_op(input op_t op);
        logic r;
        case (op)
            OP_POP_HEAD, OP_POP_TAIL, OP_PEEK_HEAD, OP_PEEK_TAIL: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/deq_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/deq_ctrl.sv
// controller: handshakes and read sequencing
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire op_t        op,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire deq_flags_t flags,
    output deq_cmd_t        cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_fire;
    logic   needs_read;

    assign needs_read = is_read_op(op) && !flags.empty;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire && needs_read) begin
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        cmd.load_read = 1'b0;
        case (state_reg)
            S_IDLE: s_tready = !out_valid_reg || m_tready;
            S_READ: cmd.load_read = 1'b1;
            default: begin
                s_tready      = 1'b0;
                cmd.load_read = 1'b0;
            end
        endcase
        in_fire      = s_tvalid && s_tready;
        cmd.take     = in_fire;
        cmd.rd_issue = in_fire && needs_read;
        cmd.load_now = in_fire && !needs_read;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_now || cmd.load_read) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/deq_dpath.sv
// datapath: head index, count, ring memory and result register
`default_nettype none

module deq_dpath
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire deq_cmd_t             cmd,
    input  wire op_t                  op,
    input  wire logic [DIN_W-1:0]     data_in,
    output deq_flags_t                flags,
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;

    logic [SW-1:0] sum_raw;
    logic [SW-1:0] tail_raw;
    logic [IW-1:0] head_dec;
    logic [IW-1:0] head_inc;

    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [IW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [63:0]           din_wide;
    logic [63:0]           rd_wide;
    status_t               res_status;

    logic [DOUT_W-1:0]    dout_reg, dout_next;
    status_t              status_reg, status_next;
    logic                 empty_reg, empty_next;
    logic [CNT_OUT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]          cnt_wide;

    // value below twice the depth folded back into the ring
    function automatic logic [IW-1:0] wrap_idx(input logic [SW-1:0] v);
        logic [IW-1:0] r;
        if (v >= SW'(DEPTH)) begin
            r = IW'(v - SW'(DEPTH));
        end else begin
            r = IW'(v);
        end
        return r;
    endfunction

    assign flags.empty = (count_reg == '0);
    assign flags.full  = (count_reg == CW'(DEPTH));

    assign sum_raw  = SW'(head_reg) + SW'(count_reg);
    assign tail_raw = sum_raw - SW'(1);
    assign head_dec = (head_reg == '0) ? IW'(DEPTH - 1) : head_reg - IW'(1);
    assign head_inc = (head_reg == IW'(DEPTH - 1)) ? '0 : head_reg + IW'(1);

    assign din_wide = 64'(data_in);
    assign wr_data  = din_wide[DATA_WIDTH-1:0];

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        rd_addr    = head_reg;
        res_status = ST_OK;
        if (cmd.take) begin
            case (op)
                OP_PUSH_HEAD: begin
                    if (flags.full) begin
                        res_status = ST_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = head_dec;
                        head_next  = head_dec;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_PUSH_TAIL: begin
                    if (flags.full) begin
                        res_status = ST_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = wrap_idx(sum_raw);
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_POP_HEAD: begin
                    if (flags.empty) begin
                        res_status = ST_EMPTY;
                    end else begin
                        head_next  = head_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                OP_PEEK_HEAD: begin
                    if (flags.empty) begin
                        res_status = ST_EMPTY;
                    end
                end
                OP_POP_TAIL: begin
                    rd_addr = wrap_idx(tail_raw);
                    if (flags.empty) begin
                        res_status = ST_EMPTY;
                    end else begin
                        count_next = count_reg - CW'(1);
                    end
                end
                OP_PEEK_TAIL: begin
                    rd_addr = wrap_idx(tail_raw);
                    if (flags.empty) begin
                        res_status = ST_EMPTY;
                    end
                end
                default: res_status = ST_OK;
            endcase
        end
    end

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_wide = 64'(rd_data);

    // on a ring read the pointers were already moved at accept time
    always_comb begin
        dout_next   = dout_reg;
        status_next = status_reg;
        empty_next  = empty_reg;
        cnt_wide    = 32'(count_next);
        cnt_next    = cnt_reg;
        if (cmd.load_read) begin
            cnt_wide    = 32'(count_reg);
            dout_next   = rd_wide[DOUT_W-1:0];
            status_next = ST_OK;
            empty_next  = flags.empty;
            cnt_next    = cnt_wide[CNT_OUT_W-1:0];
        end else if (cmd.load_now) begin
            dout_next   = '0;
            status_next = res_status;
            empty_next  = (count_next == '0);
            cnt_next    = cnt_wide[CNT_OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        dout_reg   <= dout_next;
        status_reg <= status_next;
        empty_reg  <= empty_next;
        cnt_reg    <= cnt_next;
    end

    assign m_tdata = {cnt_reg, empty_reg, status_reg, dout_reg};

endmodule

`default_nettype wire

### hw/rtl/double_ended_queue.sv
// push, refused and unused-code words load the result register when they are accepted;
// a pop or peek that finds data goes through the registered ring read, then the result register
// throughput: 1 word per cycle for pushes while the result side takes each word; a pop or peek
// holding data blocks the input until its ring read is done (registered read port of the ring)
// reset: head index and entry count cleared, no result pending; ring contents are
// left as they are, there is no clearing pass
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // operation[2:0], data_in[34:3], zero pad
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata   // data_out[31:0], status[33:32],
                                                // is_empty[34], entry_count[39:35]
);

    op_t              op;
    logic [DIN_W-1:0] data_in;
    deq_cmd_t         cmd;
    deq_flags_t       flags;

    assign op      = op_t'(s_tdata[OP_W-1:0]);
    assign data_in = s_tdata[OP_W +: DIN_W];

    deq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    deq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .op      (op),
        .data_in (data_in),
        .flags   (flags),
        .m_tdata (m_tdata)
    );

    // a ring read blocks both sides while the read is in progress, then its word shows
    a_read_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |=> !s_tready && !m_tvalid)
        else $error("input taken or result shown during ring read");

    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |-> ##2 m_tvalid)
        else $error("ring read result not presented");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(flags.empty && flags.full))
        else $error("queue both empty and full");

    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] == ST_FULL || m_tdata[33:32] == ST_EMPTY)
        |-> m_tdata[31:0] == '0)
        else $error("refused word carries data");

endmodule

`default_nettype wire

### bench/deq_checker.sv
`timescale 1ns / 100ps
// scoreboard for the double-ended queue: mirrors the ring and checks every result word

module deq_checker
    import deq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // operation[2:0], data_in[34:3], zero pad
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,   // data_out[31:0], status[33:32],
                                                 // is_empty[34], entry_count[39:35]
    output int                        fail_count,
    output int                        words_in,
    output int                        words_out,
    output int                        pending
);

    localparam int RING_N = DEPTH_DEF;
    localparam int IDX_W  = $clog2(RING_N);

    // last member sits in the lowest bits, so this matches the m_tdata layout
    typedef struct packed {
        logic [CNT_OUT_W-1:0] count;
        logic                 empty;
        status_t              status;
        logic [DOUT_W-1:0]    data;
    } deq_result_t;

    logic [DATA_WIDTH_DEF-1:0] ring [RING_N];
    logic [IDX_W-1:0]          head;
    logic [CNT_OUT_W-1:0]      held;
    deq_result_t               outcome_q [$];

    task automatic apply_op(input logic [OP_W-1:0] op, input logic [DIN_W-1:0] din,
                            output deq_result_t res);
        logic [IDX_W-1:0] slot;
        res        = '0;
        res.status = ST_OK;
        case (op)
            OP_PUSH_HEAD, OP_PUSH_TAIL: begin
                if (held == RING_N) begin
                    res.status = ST_FULL;
                end else begin
                    if (op == OP_PUSH_HEAD) begin
                        head       = head - 1'b1;
                        ring[head] = din[DATA_WIDTH_DEF-1:0];
                    end else begin
                        slot       = head + held[IDX_W-1:0];
                        ring[slot] = din[DATA_WIDTH_DEF-1:0];
                    end
                    held = held + 1'b1;
                end
            end
            OP_POP_HEAD, OP_PEEK_HEAD: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data = ring[head];
                    if (op == OP_POP_HEAD) begin
                        head = head + 1'b1;
                        held = held - 1'b1;
                    end
                end
            end
            OP_POP_TAIL, OP_PEEK_TAIL: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    slot     = head + held[IDX_W-1:0] - 1'b1;
                    res.data = ring[slot];
                    if (op == OP_POP_TAIL) begin
                        held = held - 1'b1;
                    end
                end
            end
            default: ;  // spare codes leave everything alone
        endcase
        res.empty = (held == 0);
        res.count = held;
    endtask

    always @(posedge aclk) begin : watch
        deq_result_t want;
        deq_result_t got;
        deq_result_t fresh;
        if (!aresetn) begin
            head       = '0;
            held       = '0;
            fail_count = 0;
            words_in   = 0;
            words_out  = 0;
            outcome_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                words_out++;
                if (outcome_q.size() == 0) begin
                    fail_count++;
                    $error("result word with nothing expected: %h", m_tdata);
                end else begin
                    want = outcome_q.pop_front();
                    if (got.data !== want.data) begin
                        fail_count++;
                        $error("data_out: expected %h, got %h", want.data, got.data);
                    end
                    if (got.status !== want.status) begin
                        fail_count++;
                        $error("status: expected %0d, got %0d", want.status, got.status);
                    end
                    if (got.empty !== want.empty) begin
                        fail_count++;
                        $error("is_empty: expected %0d, got %0d", want.empty, got.empty);
                    end
                    if (got.count !== want.count) begin
                        fail_count++;
                        $error("entry_count: expected %0d, got %0d", want.count, got.count);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                apply_op(s_tdata[OP_W-1:0], s_tdata[OP_W +: DIN_W], fresh);
                outcome_q.push_back(fresh);
                words_in++;
            end
        end
        pending = outcome_q.size();
    end

endmodule

### bench/tb_double_ended_queue.sv
`timescale 1ns / 100ps
// top of the double-ended queue bench: clock, reset, operation stream and verdict

module tb_double_ended_queue;
    import deq_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
    localparam int RANDOM_WORDS = 800;
    localparam int CALM_WORDS   = 120;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int   fail_count;
    int   words_in;
    int   words_out;
    int   pending;
    logic calm        = 1'b0;
    logic sender_gaps = 1'b1;

    double_ended_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    deq_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .words_in   (words_in),
        .words_out  (words_out),
        .pending    (pending)
    );

    always #6 aclk = ~aclk;

    task automatic send_word(input logic [OP_W-1:0] op, input logic [DIN_W-1:0] din);
        int gap;
        if (sender_gaps && !calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {{(S_TDATA_W-OP_W-DIN_W){1'b0}}, din, op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [DIN_W-1:0] pick_data();
        logic [DIN_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input mix_t mix);
        int               push_w;
        logic [OP_W-1:0]  op;
        case (mix)
            MIX_FILL:  push_w = 70;
            MIX_DRAIN: push_w = 25;
            default:   push_w = 50;
        endcase
        if ($urandom_range(0, 99) < 3) begin
            op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        end else if ($urandom_range(0, 99) < push_w) begin
            op = $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
        end else begin
            case ($urandom_range(0, 5))
                0, 1:    op = OP_POP_HEAD;
                2, 3:    op = OP_POP_TAIL;
                4:       op = OP_PEEK_HEAD;
                default: op = OP_PEEK_TAIL;
            endcase
        end
        return op;
    endfunction

    // result side back-pressure
    initial begin : rx_pace
        int span;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        while (!calm) begin
            if ($urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                span = $urandom_range(1, 15);
            end else begin
                m_tready <= 1'b1;
                span = $urandom_range(1, 40);
            end
            repeat (span) @(posedge aclk);
        end
        m_tready <= 1'b1;
    end

    initial begin : stimulus
        int   sent;
        int   len;
        mix_t mix;
        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty queue: every read is refused, spare code is a no-op
        send_word(OP_POP_HEAD, pick_data());
        send_word(OP_POP_TAIL, pick_data());
        send_word(OP_PEEK_HEAD, pick_data());
        send_word(OP_PEEK_TAIL, pick_data());
        send_word(OP_SPARE_A, '1);
        // fill to the brim from both ends, head pushes wrap below index zero
        for (int i = 0; i < DEPTH_DEF; i++) begin
            if (i == 0) begin
                send_word(OP_PUSH_HEAD, '0);
            end else if (i == DEPTH_DEF - 1) begin
                send_word(OP_PUSH_TAIL, '1);
            end else begin
                send_word((i % 2) ? OP_PUSH_HEAD : OP_PUSH_TAIL, pick_data());
            end
        end
        send_word(OP_PUSH_HEAD, pick_data());
        send_word(OP_PUSH_TAIL, pick_data());
        send_word(OP_SPARE_B, pick_data());
        send_word(OP_PEEK_HEAD, pick_data());
        send_word(OP_PEEK_TAIL, pick_data());

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            mix         = mix_t'($urandom_range(0, 2));
            len         = $urandom_range(10, 60);
            sender_gaps = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < len && sent < RANDOM_WORDS; i++) begin
                if (sent >= RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
                send_word(pick_op(mix), pick_data());
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("%0d operations sent, %0d result words compared with the mirrored ring",
                 words_in, words_out);
        $display("included empty and full refusals, spare codes, wrap at both ends, stalls");
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(3_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

### double_ended_queue.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_ram.sv
hw/rtl/deq_ctrl.sv
hw/rtl/deq_dpath.sv
hw/rtl/double_ended_queue.sv
bench/deq_checker.sv
bench/tb_double_ended_queue.sv
